// ===== rtl/core/sgv_pkg.sv =====
// Shared types, codes and helpers for the softened gravity Verlet body.
// No dependencies; imported by sgv_mac and softened_gravity_verlet_body.
`timescale 1ns / 1ps
`default_nettype none
package sgv_pkg;

    localparam int WORD_W = 32;
    localparam int ACC_W  = 3 * WORD_W;
    localparam int CIDX_W = 2;

    localparam logic [CIDX_W-1:0] CFG_TIME_STEP    = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_GRAV_CONST   = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_SOFTENING_SQ = 2'd2;

    localparam logic [WORD_W-1:0] RST_TIME_STEP    = 32'd655;
    localparam logic [WORD_W-1:0] RST_GRAV_CONST   = 32'd65536;
    localparam logic [WORD_W-1:0] RST_SOFTENING_SQ = 32'd655;

    typedef enum logic [2:0] {
        KIND_LOAD_POS = 3'd0,
        KIND_LOAD_VEL = 3'd1,
        KIND_LOAD_ACC = 3'd2,
        KIND_PREDICT  = 3'd3,
        KIND_INTERACT = 3'd4,
        KIND_COMMIT   = 3'd5
    } t_kind;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_ACC  = 7'b0000100,
        S_POST = 7'b0001000,
        S_SQRT = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    typedef enum logic [3:0] {
        OP_DTSQ = 4'd0,
        OP_T1   = 4'd1,
        OP_T2   = 4'd2,
        OP_V1   = 4'd3,
        OP_V2   = 4'd4,
        OP_SQ   = 4'd5,
        OP_DEN  = 4'd6,
        OP_GM   = 4'd7,
        OP_NUM  = 4'd8,
        OP_PULL = 4'd9
    } t_op;

    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic clear;
        logic high;
    } t_mac_ctl;

    function automatic logic [WORD_W-1:0] f_mag(input logic [WORD_W-1:0] v);
        return v[WORD_W-1] ? (~v + 1'b1) : v;
    endfunction

    // returns {clipped, value}
    function automatic logic [WORD_W:0] f_clip(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh0000_0000_7FFF_FFFF;
        lo = -64'sh0000_0000_8000_0000;
        if (v > hi) begin
            return {1'b1, 32'h7FFF_FFFF};
        end else if (v < lo) begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, v[WORD_W-1:0]};
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sgv_mac.sv =====
// Shared 32x32 multiplier with registered product and 96-bit accumulator.
// Depends on sgv_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sgv_mac import sgv_pkg::*; (
    input  logic              i_clk,
    input  t_mac_ctl          i_ctl,
    input  logic [WORD_W-1:0] i_op_a,
    input  logic [WORD_W-1:0] i_op_b,
    output logic [ACC_W-1:0]  o_acc
);

    logic [2*WORD_W-1:0] r_prod;
    logic [ACC_W-1:0]    r_acc;
    logic [ACC_W-1:0]    n_acc;
    logic [ACC_W-1:0]    w_addend;

    always_comb begin
        w_addend = i_ctl.high ? {r_prod, {WORD_W{1'b0}}} : {{WORD_W{1'b0}}, r_prod};
        n_acc    = (i_ctl.clear ? {ACC_W{1'b0}} : r_acc) + w_addend;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_op_a * i_op_b;
        end
        if (i_ctl.acc_en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule
`default_nettype wire

// ===== rtl/core/softened_gravity_verlet_body.sv =====
// Top level: one body's Q16.16 state, velocity Verlet under softened gravity.
// Depends on sgv_pkg and sgv_mac.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | i_valid, o_stall, i_kind..i_other_mass    | beat in
//  out     | o_valid, i_stall, o_pos_x..o_saturated    | beat out
//  cfg     | i_cfg_valid, o_cfg_ready, index, data     | write in
//
// Loads and unused kinds go straight to the result beat; predict and commit
// use one shared 32x32 multiplier, one partial product at a time, and interact
// also a 32-step square root and two 96-step restoring divisions.
// Reset (synchronous) clears state and sets registers to their defaults.
// One beat in flight: input stalls until the result beat is taken.
`timescale 1ns / 1ps
`default_nettype none
module softened_gravity_verlet_body import sgv_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [2:0]               i_kind,
    input  logic signed [WORD_W-1:0] i_x_value,
    input  logic signed [WORD_W-1:0] i_y_value,
    input  logic [WORD_W-1:0]        i_other_mass,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [WORD_W-1:0] o_pos_x,
    output logic signed [WORD_W-1:0] o_pos_y,
    output logic signed [WORD_W-1:0] o_vel_x,
    output logic signed [WORD_W-1:0] o_vel_y,
    output logic                     o_saturated,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CIDX_W-1:0]        i_cfg_index,
    input  logic [WORD_W-1:0]        i_cfg_data
);

    t_state r_state, n_state;
    t_op    r_op;
    t_kind  r_kind;
    logic   r_part, r_axis, r_sat;
    logic [6:0] r_cnt;

    logic [WORD_W-1:0] r_dt, r_g, r_soft;
    logic [WORD_W-1:0] r_pos [2];
    logic [WORD_W-1:0] r_vel [2];
    logic [WORD_W-1:0] r_accel [2];
    logic [WORD_W-1:0] r_nxt [2];
    logic [WORD_W-1:0] r_psum [2];

    logic [WORD_W-1:0] r_mass;
    logic [WORD_W-1:0] r_md [2];
    logic              r_dneg [2];
    logic [63:0]       r_dtsq;
    logic signed [63:0] r_sum;
    logic [49:0]       r_s;
    logic [63:0]       r_sqv;
    logic [34:0]       r_srem;
    logic [31:0]       r_root;
    logic [82:0]       r_den;
    logic [63:0]       r_gm;
    logic [95:0]       r_num;
    logic [83:0]       r_drem;
    logic [31:0]       r_quo;
    logic              r_qovf;

    t_mac_ctl          w_ctl;
    logic [WORD_W-1:0] w_op_a, w_op_b;
    logic [ACC_W-1:0]  w_acc;
    logic              w_accept, w_two_part;

    logic [ACC_W-1:0]   w_r16, w_r33, w_r17;
    logic [63:0]        w_mag;
    logic               w_neg;
    logic signed [63:0] w_term, w_base, w_sum;
    logic [WORD_W:0]    w_clip;
    logic [49:0]        w_snew;
    logic [34:0]        w_scur, w_strial;
    logic               w_sge;
    logic [83:0]        w_dcur;
    logic               w_dge;
    logic [WORD_W-1:0]  w_pull;
    logic               w_pull_sat;
    logic [WORD_W:0]    w_psum_clip;
    logic [32:0]        w_dx, w_dy;

    assign w_accept    = i_valid && (r_state == S_IDLE);
    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = (r_state == S_OUT);
    assign o_cfg_ready = 1'b1;
    assign o_pos_x     = r_pos[0];
    assign o_pos_y     = r_pos[1];
    assign o_vel_x     = r_vel[0];
    assign o_vel_y     = r_vel[1];
    assign o_saturated = r_sat;

    assign w_two_part = (r_op == OP_T2) || (r_op == OP_DEN) || (r_op == OP_NUM);

    always_comb begin
        w_ctl.mul_en = (r_state == S_MUL);
        w_ctl.acc_en = (r_state == S_ACC);
        w_ctl.clear  = !r_part;
        w_ctl.high   = r_part;
    end

    always_comb begin
        w_op_a = '0;
        w_op_b = '0;
        case (r_op)
            OP_DTSQ: begin
                w_op_a = r_dt;
                w_op_b = r_dt;
            end
            OP_T1: begin
                w_op_a = r_dt;
                w_op_b = f_mag(r_vel[r_axis]);
            end
            OP_T2: begin
                w_op_a = r_part ? r_dtsq[63:32] : r_dtsq[31:0];
                w_op_b = f_mag(r_accel[r_axis]);
            end
            OP_V1: begin
                w_op_a = r_dt;
                w_op_b = f_mag(r_accel[r_axis]);
            end
            OP_V2: begin
                w_op_a = r_dt;
                w_op_b = f_mag(r_psum[r_axis]);
            end
            OP_SQ: begin
                w_op_a = r_md[r_axis];
                w_op_b = r_md[r_axis];
            end
            OP_DEN: begin
                w_op_a = r_part ? {14'd0, r_s[49:32]} : r_s[31:0];
                w_op_b = r_root;
            end
            OP_GM: begin
                w_op_a = r_g;
                w_op_b = r_mass;
            end
            OP_NUM: begin
                w_op_a = r_part ? r_gm[63:32] : r_gm[31:0];
                w_op_b = r_md[r_axis];
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    sgv_mac u_mac (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_op_a (w_op_a),
        .i_op_b (w_op_b),
        .o_acc  (w_acc)
    );

    // rounding, sign and clipping of the product terms
    always_comb begin
        w_r16 = w_acc + ACC_W'(64'h8000);
        w_r33 = w_acc + ACC_W'(64'h1_0000_0000);
        w_r17 = w_acc + ACC_W'(64'h1_0000);
        case (r_op)
            OP_T1: begin
                w_mag  = w_r16[79:16];
                w_neg  = r_vel[r_axis][WORD_W-1];
                w_base = 64'(signed'(r_pos[r_axis]));
            end
            OP_T2: begin
                w_mag  = {1'b0, w_r33[95:33]};
                w_neg  = r_accel[r_axis][WORD_W-1];
                w_base = r_sum;
            end
            OP_V1: begin
                w_mag  = w_r17[80:17];
                w_neg  = r_accel[r_axis][WORD_W-1];
                w_base = 64'(signed'(r_vel[r_axis]));
            end
            default: begin
                w_mag  = w_r17[80:17];
                w_neg  = r_psum[r_axis][WORD_W-1];
                w_base = r_sum;
            end
        endcase
        w_term = w_neg ? $signed(64'd0 - w_mag) : $signed(w_mag);
        w_sum  = w_base + w_term;
        w_clip = f_clip(w_sum);
        w_snew = r_s + {2'd0, w_acc[63:16]} + {18'd0, r_soft};
    end

    always_comb begin
        w_scur   = {r_srem[32:0], r_sqv[63:62]};
        w_strial = {1'b0, r_root, 2'b01};
        w_sge    = (w_scur >= w_strial);
        w_dcur   = {r_drem[82:0], r_num[95]};
        w_dge    = (w_dcur >= {1'b0, r_den});
    end

    always_comb begin
        if (!r_dneg[r_axis]) begin
            w_pull_sat = r_qovf || r_quo[31];
            w_pull     = w_pull_sat ? 32'h7FFF_FFFF : r_quo;
        end else begin
            w_pull_sat = r_qovf || (r_quo > 32'h8000_0000);
            w_pull     = w_pull_sat ? 32'h8000_0000 : (~r_quo + 1'b1);
        end
        w_psum_clip = f_clip(64'(signed'(r_psum[r_axis])) + 64'(signed'(w_pull)));
    end

    assign w_dx = {i_x_value[WORD_W-1], i_x_value} - {r_nxt[0][WORD_W-1], r_nxt[0]};
    assign w_dy = {i_y_value[WORD_W-1], i_y_value} - {r_nxt[1][WORD_W-1], r_nxt[1]};

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_kind)
                        KIND_PREDICT, KIND_COMMIT, KIND_INTERACT: n_state = S_MUL;
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_MUL: n_state = S_ACC;
            S_ACC: n_state = (w_two_part && !r_part) ? S_MUL : S_POST;
            S_POST: begin
                case (r_op)
                    OP_T2: begin
                        if (r_kind == KIND_COMMIT || !r_axis) begin
                            n_state = S_MUL;
                        end else begin
                            n_state = S_OUT;
                        end
                    end
                    OP_V2, OP_PULL: n_state = r_axis ? S_OUT : S_MUL;
                    OP_SQ: begin
                        if (!r_axis) begin
                            n_state = S_MUL;
                        end else begin
                            n_state = (w_snew == '0) ? S_OUT : S_SQRT;
                        end
                    end
                    OP_NUM:  n_state = S_DIV;
                    default: n_state = S_MUL;
                endcase
            end
            S_SQRT: n_state = (r_cnt == '0) ? S_MUL : S_SQRT;
            S_DIV:  n_state = (r_cnt == '0) ? S_POST : S_DIV;
            S_OUT:  n_state = i_stall ? S_OUT : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_DTSQ;
            r_kind  <= KIND_LOAD_POS;
            r_part  <= 1'b0;
            r_axis  <= 1'b0;
            r_sat   <= 1'b0;
            r_cnt   <= '0;
            r_dt    <= RST_TIME_STEP;
            r_g     <= RST_GRAV_CONST;
            r_soft  <= RST_SOFTENING_SQ;
            for (int i = 0; i < 2; i++) begin
                r_pos[i]   <= '0;
                r_vel[i]   <= '0;
                r_accel[i] <= '0;
                r_nxt[i]   <= '0;
                r_psum[i]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_TIME_STEP:    r_dt   <= i_cfg_data;
                    CFG_GRAV_CONST:   r_g    <= i_cfg_data;
                    CFG_SOFTENING_SQ: r_soft <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_kind    <= t_kind'(i_kind);
                        r_sat     <= 1'b0;
                        r_part    <= 1'b0;
                        r_axis    <= 1'b0;
                        r_mass    <= i_other_mass;
                        r_dneg[0] <= w_dx[32];
                        r_dneg[1] <= w_dy[32];
                        r_md[0]   <= w_dx[32] ? (~w_dx[31:0] + 1'b1) : w_dx[31:0];
                        r_md[1]   <= w_dy[32] ? (~w_dy[31:0] + 1'b1) : w_dy[31:0];
                        case (i_kind)
                            KIND_LOAD_POS: begin
                                r_pos[0] <= i_x_value;
                                r_pos[1] <= i_y_value;
                                r_nxt[0] <= i_x_value;
                                r_nxt[1] <= i_y_value;
                            end
                            KIND_LOAD_VEL: begin
                                r_vel[0] <= i_x_value;
                                r_vel[1] <= i_y_value;
                            end
                            KIND_LOAD_ACC: begin
                                r_accel[0] <= i_x_value;
                                r_accel[1] <= i_y_value;
                            end
                            KIND_PREDICT, KIND_COMMIT: r_op <= OP_DTSQ;
                            KIND_INTERACT: r_op <= OP_SQ;
                            default: ;
                        endcase
                    end
                end
                S_ACC: begin
                    if (w_two_part && !r_part) begin
                        r_part <= 1'b1;
                    end
                end
                S_POST: begin
                    r_part <= 1'b0;
                    case (r_op)
                        OP_DTSQ: begin
                            r_dtsq <= w_acc[63:0];
                            r_op   <= OP_T1;
                        end
                        OP_T1: begin
                            r_sum <= w_sum;
                            r_op  <= OP_T2;
                        end
                        OP_T2: begin
                            r_nxt[r_axis] <= w_clip[WORD_W-1:0];
                            r_sat         <= r_sat | w_clip[WORD_W];
                            if (r_kind == KIND_COMMIT) begin
                                r_op <= OP_V1;
                            end else begin
                                r_psum[r_axis] <= '0;
                                r_axis         <= 1'b1;
                                r_op           <= OP_T1;
                            end
                        end
                        OP_V1: begin
                            r_sum <= w_sum;
                            r_op  <= OP_V2;
                        end
                        OP_V2: begin
                            r_vel[r_axis]   <= w_clip[WORD_W-1:0];
                            r_sat           <= r_sat | w_clip[WORD_W];
                            r_pos[r_axis]   <= r_nxt[r_axis];
                            r_accel[r_axis] <= r_psum[r_axis];
                            r_axis          <= 1'b1;
                            r_op            <= OP_T1;
                        end
                        OP_SQ: begin
                            if (!r_axis) begin
                                r_s    <= {2'd0, w_acc[63:16]};
                                r_axis <= 1'b1;
                            end else begin
                                r_s    <= w_snew;
                                r_sqv  <= {w_snew, 14'd0};
                                r_srem <= '0;
                                r_root <= '0;
                                r_cnt  <= 7'd31;
                                r_axis <= 1'b0;
                                r_op   <= OP_DEN;
                            end
                        end
                        OP_DEN: begin
                            r_den <= {w_acc[81:0], 1'b0};
                            r_op  <= OP_GM;
                        end
                        OP_GM: begin
                            r_gm <= w_acc[63:0];
                            r_op <= OP_NUM;
                        end
                        OP_NUM: begin
                            r_num  <= w_acc;
                            r_drem <= '0;
                            r_quo  <= '0;
                            r_qovf <= 1'b0;
                            r_cnt  <= 7'd95;
                            r_op   <= OP_PULL;
                        end
                        OP_PULL: begin
                            r_psum[r_axis] <= w_psum_clip[WORD_W-1:0];
                            r_sat  <= r_sat | w_pull_sat | w_psum_clip[WORD_W];
                            r_axis <= 1'b1;
                            r_op   <= OP_NUM;
                        end
                        default: ;
                    endcase
                end
                S_SQRT: begin
                    r_srem <= w_sge ? (w_scur - w_strial) : w_scur;
                    r_root <= {r_root[30:0], w_sge};
                    r_sqv  <= {r_sqv[61:0], 2'b00};
                    r_cnt  <= r_cnt - 1'b1;
                end
                S_DIV: begin
                    r_drem <= w_dge ? (w_dcur - {1'b0, r_den}) : w_dcur;
                    r_quo  <= {r_quo[30:0], w_dge};
                    r_qovf <= r_qovf | r_quo[31];
                    r_num  <= {r_num[94:0], 1'b0};
                    r_cnt  <= r_cnt - 1'b1;
                end
                default: ;
            endcase
        end
    end

    a_busy_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("result shown while input open");

    a_load_is_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_kind == KIND_LOAD_VEL) |=> (o_valid && !o_saturated))
        else $error("load beat did not complete at once");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_den != '0)) else $error("division by zero denominator");

endmodule
`default_nettype wire
